// File: sv/tcw_pkg.sv
// Shared definitions for the text console writer: opcodes, register indexes,
// character and blank-cell constants, and the put-step control struct.
// No dependencies.
package tcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int OPCODE_W = 2;
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int DATA_W   = 16;
  localparam int OUT_ROW_W = 5;
  localparam int OUT_COL_W = 7;
  localparam int ATTR_W   = 8;
  localparam int MINCOL_W = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } opcode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ERASE = 1'b1;

  localparam logic [ATTR_W-1:0]   ATTR_RESET      = 8'h07;
  localparam logic [MINCOL_W-1:0] MIN_ERASE_RESET = 7'd2;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h0E;
  localparam logic [CHAR_W-1:0] CH_CURSOR    = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [DATA_W-1:0] BLANK_WHITE = 16'h0F20;
  localparam logic [DATA_W-1:0] BLANK_GREY  = 16'h0720;

  // What the first write of a put does, and whether a scroll follows it.
  typedef struct packed {
    logic              scroll;
    logic [CHAR_W-1:0] first_char;
  } put_ctl_t;

endpackage

// File: sv/tcw_cursor.sv
// Cursor step for a put request: next row and column, the character stored
// at the old cursor cell, and the scroll request. Uses tcw_pkg.
module tcw_cursor #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS,
  localparam int COL_W  = $clog2(COLUMNS),
  localparam int ROW_W  = $clog2(ROWS)
) (
  input  logic [ROW_W-1:0]             row,
  input  logic [COL_W-1:0]             col,
  input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
  input  logic [tcw_pkg::MINCOL_W-1:0] min_erase_column,
  output logic [ROW_W-1:0]             row_next,
  output logic [COL_W-1:0]             col_next,
  output tcw_pkg::put_ctl_t            ctl
);

  logic last_row;
  logic last_col;

  assign last_row = (row == ROW_W'(ROWS - 1));
  assign last_col = (col == COL_W'(COLUMNS - 1));

  always_comb begin
    row_next       = row;
    col_next       = col;
    ctl.scroll     = 1'b0;
    ctl.first_char = tcw_pkg::CH_SPACE;
    if (char_code == tcw_pkg::CH_NEWLINE) begin
      col_next = '0;
      // on the last row the row stays and the screen scrolls
      if (last_row) begin
        ctl.scroll = 1'b1;
      end else begin
        row_next = row + ROW_W'(1);
      end
    end else if (char_code == tcw_pkg::CH_BACKSPACE) begin
      // the blanked cell is overwritten by the cursor anyway
      if (8'(col) > 8'(min_erase_column)) begin
        col_next = col - COL_W'(1);
      end
    end else begin
      ctl.first_char = char_code;
      if (last_col) begin
        col_next = '0;
        row_next = last_row ? '0 : row + ROW_W'(1);
      end else begin
        col_next = col + COL_W'(1);
      end
    end
  end

endmodule

// File: sv/text_console_writer_top.sv
// Text console writer top level: screen memory, cursor, sequencer and
// output register. Uses tcw_pkg and tcw_cursor.
//
// Usage: requests enter on in_valid/in_ready (opcode, char_code,
// cell_index); each gives exactly one result on out_valid/out_ready
// (cell_data, cursor_row, cursor_column). The user writes registers on
// cfg_we with cfg_index/cfg_data while the block is idle (not enforced).
// Requests are handled one at a time; the screen lives in one RAM with one
// write and one registered read port, so at most one cell is written and
// one read at a time. A put writes the old cursor cell, then the cursor at
// the new cell; a newline on the last row copies every row up and blanks
// the last row before the cursor is written. A clear fills the screen with
// white blanks, then writes the cursor. A read in range reads its cell; a
// read out of range or an unused opcode answers with zero data at once.
// After reset a fill pass sets every cell to grey space; in_ready stays low
// during it. The result waits in an output register, and the next request
// is taken while it waits; a finished result holds the sequencer until the
// output register frees up.
module text_console_writer_top #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tcw_pkg::OPCODE_W-1:0]    opcode,
  input  logic [tcw_pkg::CHAR_W-1:0]      char_code,
  input  logic [tcw_pkg::INDEX_W-1:0]     cell_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tcw_pkg::DATA_W-1:0]      cell_data,
  output logic [tcw_pkg::OUT_ROW_W-1:0]   cursor_row,
  output logic [tcw_pkg::OUT_COL_W-1:0]   cursor_column,
  input  logic                            cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int CELL_W = $clog2(CELL_COUNT);
  localparam int CNT_W  = $clog2(CELL_COUNT + 1);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);

  typedef enum logic [7:0] {
    S_INIT   = 8'b00000001,
    S_IDLE   = 8'b00000010,
    S_WRITE  = 8'b00000100,
    S_SCROLL = 8'b00001000,
    S_BLANK  = 8'b00010000,
    S_CURSOR = 8'b00100000,
    S_RDATA  = 8'b01000000,
    S_RESP   = 8'b10000000
  } state_t;

  state_t state;

  logic [tcw_pkg::DATA_W-1:0] screen [CELL_COUNT];
  logic                       mem_we;
  logic [CELL_W-1:0]          mem_waddr;
  logic [tcw_pkg::DATA_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [CELL_W-1:0]          mem_raddr;
  logic [tcw_pkg::DATA_W-1:0] mem_q;

  logic [ROW_W-1:0]             row;
  logic [COL_W-1:0]             col;
  logic [ROW_W-1:0]             row_next;
  logic [COL_W-1:0]             col_next;
  logic [tcw_pkg::ATTR_W-1:0]   text_attribute;
  logic [tcw_pkg::MINCOL_W-1:0] min_erase_column;
  logic [tcw_pkg::CHAR_W-1:0]   ch;
  tcw_pkg::put_ctl_t            put_ctl;

  logic [CNT_W-1:0]           cnt;
  logic                       cp_valid;
  logic [CELL_W-1:0]          cp_addr;
  logic [tcw_pkg::DATA_W-1:0] res_data;
  logic [CELL_W-1:0]          cur_addr;
  logic                       accept;
  logic                       read_in_range;
  logic                       out_free;

  assign in_ready      = (state == S_IDLE);
  assign accept        = in_valid && in_ready;
  assign read_in_range = (32'(cell_index) < 32'(CELL_COUNT));
  assign cur_addr      = CELL_W'(row) * CELL_W'(COLUMNS) + CELL_W'(col);
  assign out_free      = !out_valid || out_ready;

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .row              (row),
    .col              (col),
    .char_code        (ch),
    .min_erase_column (min_erase_column),
    .row_next         (row_next),
    .col_next         (col_next),
    .ctl              (put_ctl)
  );

  // Memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = {text_attribute, tcw_pkg::CH_CURSOR};
    mem_re    = 1'b0;
    mem_raddr = cnt[CELL_W-1:0];
    case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt[CELL_W-1:0];
        mem_wdata = tcw_pkg::BLANK_GREY;
      end
      S_IDLE: begin
        mem_re    = accept && (opcode == tcw_pkg::OP_READ) && read_in_range;
        mem_raddr = CELL_W'(cell_index);
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = {text_attribute, put_ctl.first_char};
      end
      S_SCROLL: begin
        // reads run COLUMNS cells ahead of writes, so they never meet
        mem_re    = (cnt != CNT_W'(CELL_COUNT));
        mem_we    = cp_valid;
        mem_waddr = cp_addr;
        mem_wdata = mem_q;
      end
      S_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = cnt[CELL_W-1:0];
        mem_wdata = tcw_pkg::BLANK_WHITE;
      end
      S_CURSOR: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= screen[mem_raddr];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_INIT;
      cnt              <= '0;
      cp_valid         <= 1'b0;
      row              <= '0;
      col              <= '0;
      text_attribute   <= tcw_pkg::ATTR_RESET;
      min_erase_column <= tcw_pkg::MIN_ERASE_RESET;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tcw_pkg::CFG_TEXT_ATTR: text_attribute <= cfg_data;
          tcw_pkg::CFG_MIN_ERASE: min_erase_column <= cfg_data[tcw_pkg::MINCOL_W-1:0];
          default: ;
        endcase
      end

      if (state == S_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_INIT: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(CELL_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            ch       <= char_code;
            res_data <= '0;
            case (opcode)
              tcw_pkg::OP_PUT: state <= S_WRITE;
              tcw_pkg::OP_CLEAR: begin
                cnt   <= '0;
                row   <= '0;
                col   <= '0;
                state <= S_BLANK;
              end
              tcw_pkg::OP_READ: state <= read_in_range ? S_RDATA : S_RESP;
              default: state <= S_RESP;
            endcase
          end
        end
        S_WRITE: begin
          row <= row_next;
          col <= col_next;
          if (put_ctl.scroll) begin
            cnt      <= CNT_W'(COLUMNS);
            cp_valid <= 1'b0;
            state    <= S_SCROLL;
          end else begin
            state <= S_CURSOR;
          end
        end
        S_SCROLL: begin
          cp_addr <= cnt[CELL_W-1:0] - CELL_W'(COLUMNS);
          if (cnt == CNT_W'(CELL_COUNT)) begin
            cp_valid <= 1'b0;
            cnt      <= CNT_W'(CELL_COUNT - COLUMNS);
            state    <= S_BLANK;
          end else begin
            cp_valid <= 1'b1;
            cnt      <= cnt + CNT_W'(1);
          end
        end
        S_BLANK: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(CELL_COUNT - 1)) begin
            state <= S_CURSOR;
          end
        end
        S_CURSOR: begin
          state <= S_RESP;
        end
        S_RDATA: begin
          res_data <= mem_q;
          state    <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            cell_data     <= res_data;
            cursor_row    <= tcw_pkg::OUT_ROW_W'(row);
            cursor_column <= tcw_pkg::OUT_COL_W'(col);
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !mem_we)
    else $error("screen written while idle");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    32'(col) < 32'(COLUMNS))
    else $error("cursor column out of range");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    32'(row) < 32'(ROWS))
    else $error("cursor row out of range");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("second request taken while busy");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    state == S_RESP && out_valid && !out_ready |=> state == S_RESP && out_valid)
    else $error("result overwrote a stalled output");
`endif

endmodule

// File: test/tb_text_console_writer_top.sv
`timescale 1ns / 1ps
// Testbench for text_console_writer_top: a queue-fed request driver, a result
// monitor and an in-line model of the screen and cursor.
// Depends on tcw_pkg and the text_console_writer_top RTL.
module tb_text_console_writer_top;

  localparam int COLS = tcw_pkg::DEF_COLUMNS;
  localparam int NROWS = tcw_pkg::DEF_ROWS;
  localparam int CELLS = COLS * NROWS;
  localparam logic [tcw_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 12000;
  localparam int PRESSURE_AT = 1000;
  localparam int PRESSURE_LEN = 300;
  localparam int MAX_REPORTS = 10;

  typedef logic [tcw_pkg::OPCODE_W-1:0]   op_bits_t;
  typedef logic [tcw_pkg::CHAR_W-1:0]     char_t;
  typedef logic [tcw_pkg::INDEX_W-1:0]    index_t;
  typedef logic [tcw_pkg::CFG_DATA_W-1:0] cfg_word_t;

  typedef struct {
    op_bits_t op;
    char_t    ch;
    index_t   idx;
  } console_req_t;

  typedef struct {
    logic [tcw_pkg::DATA_W-1:0]    data;
    logic [tcw_pkg::OUT_ROW_W-1:0] row;
    logic [tcw_pkg::OUT_COL_W-1:0] col;
  } console_view_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [tcw_pkg::OPCODE_W-1:0] opcode = '0;
  logic [tcw_pkg::CHAR_W-1:0] char_code = '0;
  logic [tcw_pkg::INDEX_W-1:0] cell_index = '0;
  logic out_ready = 1'b0;
  logic cfg_we = 1'b0;
  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_ready;
  logic out_valid;
  logic [tcw_pkg::DATA_W-1:0] cell_data;
  logic [tcw_pkg::OUT_ROW_W-1:0] cursor_row;
  logic [tcw_pkg::OUT_COL_W-1:0] cursor_column;

  text_console_writer_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .char_code(char_code),
    .cell_index(cell_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cell_data(cell_data),
    .cursor_row(cursor_row),
    .cursor_column(cursor_column),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  console_req_t console_requests[$];
  console_view_t predicted_views[$];
  console_req_t offered_req;
  console_req_t taken_req;
  console_view_t want;

  // model state
  logic [tcw_pkg::DATA_W-1:0] screen_model [CELLS];
  int cur_row;
  int cur_col;
  logic [tcw_pkg::ATTR_W-1:0] model_attr;
  logic [tcw_pkg::MINCOL_W-1:0] model_min_erase;

  int sender_idle_pct;
  int receiver_idle_pct;
  int results_seen = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit pressure_done = 1'b0;
  bit req_taken = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic char_t rand_char();
    return char_t'($urandom_range(255));
  endfunction

  function automatic index_t rand_index(input int hi);
    return index_t'($urandom_range(hi));
  endfunction

  function automatic void draw_at_cursor(input logic [tcw_pkg::CHAR_W-1:0] ch);
    int pos;
    pos = cur_row * COLS + cur_col;
    if (pos < CELLS) screen_model[pos] = {model_attr, ch};
  endfunction

  function automatic console_view_t apply_console_request(input console_req_t req);
    console_view_t view;
    int i;
    view.data = '0;
    case (req.op)
      tcw_pkg::OP_PUT: begin
        draw_at_cursor(tcw_pkg::CH_SPACE);
        if (req.ch == tcw_pkg::CH_NEWLINE) begin
          cur_col = 0;
          cur_row++;
          if (cur_row >= NROWS) begin
            for (i = 0; i < CELLS - COLS; i++) screen_model[i] = screen_model[i + COLS];
            for (i = CELLS - COLS; i < CELLS; i++) screen_model[i] = tcw_pkg::BLANK_WHITE;
            cur_row = NROWS - 1;
          end
        end else if (req.ch == tcw_pkg::CH_BACKSPACE) begin
          if (cur_col > model_min_erase) begin
            cur_col--;
            draw_at_cursor(tcw_pkg::CH_SPACE);
          end
        end else begin
          draw_at_cursor(req.ch);
          cur_col++;
          // wrap past the last row goes back to the top, no scroll
          if (cur_col >= COLS) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= NROWS) cur_row = 0;
          end
        end
        draw_at_cursor(tcw_pkg::CH_CURSOR);
      end
      tcw_pkg::OP_CLEAR: begin
        for (i = 0; i < CELLS; i++) screen_model[i] = tcw_pkg::BLANK_WHITE;
        cur_row = 0;
        cur_col = 0;
        draw_at_cursor(tcw_pkg::CH_CURSOR);
      end
      tcw_pkg::OP_READ: begin
        if (req.idx < CELLS) view.data = screen_model[req.idx];
      end
      default: ;
    endcase
    view.row = cur_row[tcw_pkg::OUT_ROW_W-1:0];
    view.col = cur_col[tcw_pkg::OUT_COL_W-1:0];
    return view;
  endfunction

  task automatic push_req(input op_bits_t op, input char_t ch, input index_t idx);
    console_req_t req;
    req.op = op;
    req.ch = ch;
    req.idx = idx;
    console_requests.push_back(req);
  endtask

  // Mostly text lines and newline bursts so the cursor reaches the bottom,
  // scrolls and wraps; reads sample the screen; the rest is noise.
  task automatic plan_random(input int count);
    int made;
    int kind;
    int len;
    int i;
    made = 0;
    while (made < count) begin
      kind = $urandom_range(99);
      if (kind < 45) begin
        case ($urandom_range(4))
          0, 1: len = $urandom_range(5);
          2, 3: len = $urandom_range(COLS - 1);
          default: len = $urandom_range(COLS + 20, COLS - 10);
        endcase
        for (i = 0; i < len; i++) begin
          if ($urandom_range(9) == 0)
            push_req(tcw_pkg::OP_PUT, tcw_pkg::CH_BACKSPACE, rand_index(2047));
          else
            push_req(tcw_pkg::OP_PUT, rand_char(), rand_index(2047));
        end
        push_req(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE, rand_index(2047));
        made += len + 1;
      end else if (kind < 58) begin
        len = $urandom_range(12, 1);
        for (i = 0; i < len; i++)
          push_req(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE, rand_index(2047));
        made += len;
      end else if (kind < 72) begin
        len = $urandom_range(4, 1);
        for (i = 0; i < len; i++) begin
          if ($urandom_range(6) == 0)
            push_req(tcw_pkg::OP_READ, rand_char(), rand_index(2047));
          else
            push_req(tcw_pkg::OP_READ, rand_char(), rand_index(CELLS - 1));
        end
        made += len;
      end else if (kind < 75) begin
        push_req(tcw_pkg::OP_CLEAR, rand_char(), rand_index(2047));
        made++;
      end else if (kind < 77) begin
        push_req(OP_UNUSED, rand_char(), rand_index(2047));
        made++;
      end else begin
        push_req(op_bits_t'($urandom_range(3)), rand_char(), rand_index(2047));
        made++;
      end
    end
  endtask

  task automatic write_register(input logic [tcw_pkg::CFG_IDX_W-1:0] idx,
                                input logic [tcw_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == tcw_pkg::CFG_TEXT_ATTR) model_attr = value[tcw_pkg::ATTR_W-1:0];
    else model_min_erase = value[tcw_pkg::MINCOL_W-1:0];
  endtask

  task automatic wait_drained();
    while (console_requests.size() != 0 || in_valid || predicted_views.size() != 0)
      @(posedge clk);
    repeat (10) @(negedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (console_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        offered_req = console_requests.pop_front();
        in_valid <= 1'b1;
        opcode <= offered_req.op;
        char_code <= offered_req.ch;
        cell_index <= offered_req.idx;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off to back up the block
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!pressure_done && results_seen >= PRESSURE_AT) begin
      pressure_done = 1'b1;
      hold_left = PRESSURE_LEN;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // monitor: check results first, then predict the newly taken request
  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        results_seen++;
        if (predicted_views.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: unexpected result data %h row %0d col %0d", $realtime,
                     cell_data, cursor_row, cursor_column);
        end else begin
          want = predicted_views.pop_front();
          if (cell_data !== want.data || cursor_row !== want.row ||
              cursor_column !== want.col) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("%0t: result %0d expected data %h row %0d col %0d, %s %h row %0d col %0d",
                       $realtime, results_seen, want.data, want.row, want.col,
                       "got data", cell_data, cursor_row, cursor_column);
          end
        end
      end
      if (in_valid && in_ready) begin
        taken_req.op = opcode;
        taken_req.ch = char_code;
        taken_req.idx = cell_index;
        predicted_views.push_back(apply_console_request(taken_req));
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_text_console_writer_top: FAIL");
      $finish;
    end
  end

  initial begin
    foreach (screen_model[i]) screen_model[i] = tcw_pkg::BLANK_GREY;
    cur_row = 0;
    cur_col = 0;
    model_attr = tcw_pkg::ATTR_RESET;
    model_min_erase = tcw_pkg::MIN_ERASE_RESET;
    sender_idle_pct = 8;
    receiver_idle_pct = 79;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, reset register values
    push_req(tcw_pkg::OP_READ, 8'h00, 11'd0);
    push_req(tcw_pkg::OP_READ, 8'hFF, 11'd1999);
    push_req(tcw_pkg::OP_READ, 8'h00, 11'd2000);
    push_req(tcw_pkg::OP_READ, 8'h00, 11'h7FF);
    push_req(OP_UNUSED, 8'hFF, 11'h7FF);
    push_req(tcw_pkg::OP_PUT, 8'h41, 11'd0);
    push_req(tcw_pkg::OP_PUT, 8'h00, 11'h7FF);
    push_req(tcw_pkg::OP_PUT, 8'hFF, 11'd0);
    push_req(tcw_pkg::OP_PUT, tcw_pkg::CH_BACKSPACE, 11'd0);
    push_req(tcw_pkg::OP_PUT, tcw_pkg::CH_BACKSPACE, 11'd0);
    push_req(tcw_pkg::OP_READ, 8'h00, 11'd0);
    push_req(tcw_pkg::OP_READ, 8'h00, 11'd2);
    push_req(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE, 11'd0);
    push_req(tcw_pkg::OP_READ, 8'h00, 11'd80);
    push_req(tcw_pkg::OP_CLEAR, 8'hFF, 11'h7FF);
    push_req(tcw_pkg::OP_READ, 8'h00, 11'd0);
    push_req(tcw_pkg::OP_READ, 8'h00, 11'd1);
    push_req(tcw_pkg::OP_PUT, tcw_pkg::CH_BACKSPACE, 11'd0);
    push_req(tcw_pkg::OP_PUT, tcw_pkg::CH_CURSOR, 11'd0);
    push_req(tcw_pkg::OP_PUT, tcw_pkg::CH_SPACE, 11'd0);
    wait_drained();

    write_register(tcw_pkg::CFG_TEXT_ATTR, 8'hFF);
    write_register(tcw_pkg::CFG_MIN_ERASE, 8'd0);
    plan_random(300);
    wait_drained();

    sender_idle_pct = 79;
    receiver_idle_pct = 8;
    write_register(tcw_pkg::CFG_TEXT_ATTR, 8'h00);
    write_register(tcw_pkg::CFG_MIN_ERASE, 8'd79);
    plan_random(300);
    wait_drained();

    // min erase column beyond the row width: backspace never moves
    write_register(tcw_pkg::CFG_TEXT_ATTR, cfg_word_t'($urandom_range(255)));
    write_register(tcw_pkg::CFG_MIN_ERASE, 8'd127);
    plan_random(200);
    wait_drained();

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    write_register(tcw_pkg::CFG_TEXT_ATTR, 8'h1E);
    write_register(tcw_pkg::CFG_MIN_ERASE, 8'd5);
    plan_random(400);
    wait_drained();

    if (mismatch_count == 0 && predicted_views.size() == 0)
      $display("tb_text_console_writer_top: PASS");
    else
      $display("tb_text_console_writer_top: FAIL");
    $finish;
  end

endmodule
